// ===== design/fbik_pkg.sv =====
// Package for the five-bar inverse kinematics block.
// Holds widths, register indexes and the arctangent table.
package fbik_pkg;
	localparam int COORD_WIDTH = 24;
	localparam int CFG_WIDTH = 22;
	localparam int ANGLE_WIDTH = 32;
	localparam int CORDIC_STEPS = 28;
	localparam int ISQRT_STEPS = 31;   // 62-bit radicand, one result bit per stage
	localparam int DIV_STEPS = 30;
	localparam int DIV_SIDE_W = 2;     // flag bits carried beside each quotient
	localparam int CW = 34;            // CORDIC x/y width
	localparam int ZW = 32;

	typedef enum logic [1:0] {
		REG_HALF_BASE = 2'd0,
		REG_UPPER_LINK = 2'd1,
		REG_LOWER_LINK = 2'd2
	} reg_idx_t;

	localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
	localparam logic [30:0] ONE_Q30 = 31'h40000000;

	function automatic logic signed [ZW-1:0] atan_q28(input logic [4:0] i);
		case (i)
			5'd0: atan_q28 = 32'sd210828714;
			5'd1: atan_q28 = 32'sd124459457;
			5'd2: atan_q28 = 32'sd65760959;
			5'd3: atan_q28 = 32'sd33381290;
			5'd4: atan_q28 = 32'sd16755422;
			5'd5: atan_q28 = 32'sd8385879;
			5'd6: atan_q28 = 32'sd4193963;
			5'd7: atan_q28 = 32'sd2097109;
			5'd8: atan_q28 = 32'sd1048571;
			5'd9: atan_q28 = 32'sd524287;
			default: atan_q28 = 32'sd1 <<< (5'd28 - i);
		endcase
	endfunction
endpackage

// ===== design/fbik_isqrt.sv =====
// Pipelined floor square root of a 62-bit value, one result bit per stage.
// Depends on fbik_pkg.
module fbik_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [61:0] in_val,
	output logic        out_valid,
	output logic [30:0] out_root
);
	localparam int N = fbik_pkg::ISQRT_STEPS;
	logic [N:0]  vld;
	logic [61:0] rem [N+1];
	logic [30:0] root [N+1];

	assign vld[0] = in_valid;
	assign rem[0] = in_val;
	assign root[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_st
		localparam int SH = 2 * (N - 1 - k);
		logic [63:0] trial;
		logic [63:0] remw;
		logic        ge;
		assign trial = ({33'd0, root[k]} << (SH + 2)) | (64'd1 << SH);
		assign remw = {2'b00, rem[k]};
		assign ge = remw >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem[k+1] <= ge ? 62'(remw - trial) : rem[k];
				root[k+1] <= {root[k][29:0], ge};
			end
		end
	end

	assign out_valid = vld[N];
	assign out_root = root[N];
endmodule

// ===== design/fbik_div.sv =====
// Pipelined restoring divider: trunc(mag * 2^30 / den), clamped to 2^30.
// Depends on fbik_pkg. One quotient bit per stage, flag bits carried along.
module fbik_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [47:0]                     in_mag,
	input  logic [47:0]                     in_den,
	input  logic [fbik_pkg::DIV_SIDE_W-1:0] in_side,
	output logic                            out_valid,
	output logic [30:0]                     out_q,
	output logic [fbik_pkg::DIV_SIDE_W-1:0] out_side
);
	localparam int N = fbik_pkg::DIV_STEPS;
	localparam int SW = fbik_pkg::DIV_SIDE_W;
	logic [N:0]    vld;
	logic [48:0]   rem [N+1];
	logic [47:0]   den [N+1];
	logic [29:0]   q [N+1];
	logic          sat [N+1];
	logic [SW-1:0] side [N+1];

	assign vld[0] = in_valid;
	assign rem[0] = {1'b0, in_mag};
	assign den[0] = in_den;
	assign q[0] = '0;
	assign sat[0] = in_mag >= in_den;
	assign side[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_st
		logic [49:0] sh;
		logic        ge;
		assign sh = {rem[k], 1'b0};
		assign ge = sh >= {2'b00, den[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem[k+1] <= ge ? 49'(sh - {2'b00, den[k]}) : sh[48:0];
				q[k+1] <= {q[k][28:0], ge};
				den[k+1] <= den[k];
				sat[k+1] <= sat[k];
				side[k+1] <= side[k];
			end
		end
	end

	assign out_valid = vld[N];
	assign out_q = sat[N] ? fbik_pkg::ONE_Q30 : {1'b0, q[N]};
	assign out_side = side[N];
endmodule

// ===== design/fbik_acos.sv =====
// Pipelined arccosine of a signed Q.30 argument: square root for the sine leg,
// then a 28-stage vectoring CORDIC. Depends on fbik_pkg and fbik_isqrt.
module fbik_acos (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [31:0]       in_c,
	input  logic                     in_side,
	output logic                     out_valid,
	output logic signed [31:0]       out_z,
	output logic                     out_side
);
	localparam int N = fbik_pkg::CORDIC_STEPS;
	localparam int W = fbik_pkg::CW;
	localparam int NS = fbik_pkg::ISQRT_STEPS;
	logic [30:0]       cm;
	logic [61:0]       sq;
	logic [61:0]       rad_s1;
	logic              v_s1;
	logic signed [31:0] c_s1;
	logic              side_s1;
	logic              sv;
	logic [30:0]       sy;

	assign cm = in_c[31] ? 31'(-in_c) : in_c[30:0];

	// square the magnitude; 31x31 product registered before the root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	assign sq = 62'({31'd0, cm} * {31'd0, cm});
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= 62'(63'd1 << 60) - sq;
			c_s1 <= in_c;
			side_s1 <= in_side;
		end
	end

	fbik_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s1), .in_val(rad_s1),
		.out_valid(sv), .out_root(sy)
	);

	// carry the argument and the side bit beside the root stages
	logic signed [31:0] cd [NS+1];
	logic               sd [NS+1];
	assign cd[0] = c_s1;
	assign sd[0] = side_s1;
	for (genvar k = 0; k < NS; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				cd[k+1] <= cd[k];
				sd[k+1] <= sd[k];
			end
		end
	end

	logic [N:0]                vld;
	logic signed [W-1:0]       x [N+1];
	logic signed [W-1:0]       y [N+1];
	logic signed [31:0]        z [N+1];
	logic                      side [N+1];
	logic signed [31:0]        sc;

	assign sc = cd[NS];
	assign vld[0] = sv;
	// negative argument: pre-rotate by -pi/2
	assign x[0] = sc[31] ? W'($signed({1'b0, sy})) : W'(sc);
	assign y[0] = sc[31] ? -W'(sc) : W'($signed({1'b0, sy}));
	assign z[0] = sc[31] ? fbik_pkg::HALF_PI_Q28 : '0;
	assign side[0] = sd[NS];

	for (genvar k = 0; k < N; k++) begin : g_st
		logic signed [W-1:0] xs, ys;
		assign xs = x[k] >>> k;
		assign ys = y[k] >>> k;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (y[k] > 0) begin
					x[k+1] <= x[k] + ys;
					y[k+1] <= y[k] - xs;
					z[k+1] <= z[k] + fbik_pkg::atan_q28(5'(k));
				end else begin
					x[k+1] <= x[k] - ys;
					y[k+1] <= y[k] + xs;
					z[k+1] <= z[k] - fbik_pkg::atan_q28(5'(k));
				end
				side[k+1] <= side[k];
			end
		end
	end

	assign out_valid = vld[N];
	assign out_z = z[N];
	assign out_side = side[N];
endmodule

// ===== design/fbik_side.sv =====
// One pivot side: radius, both acos arguments and both angles.
// Depends on fbik_pkg, fbik_isqrt, fbik_div and fbik_acos.
module fbik_side (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [25:0] d,
	input  logic signed [23:0] ty,
	input  logic [21:0]        a_len,
	input  logic [21:0]        b_len,
	output logic               out_valid,
	output logic signed [31:0] eef,
	output logic signed [31:0] link,
	output logic               ok
);
	// stage 1: magnitudes and squares
	logic        v_s1, dn_s1;
	logic [25:0] dm;
	logic [23:0] ym;
	logic [50:0] d2_s1;
	logic [47:0] y2_s1, y2w;
	logic [43:0] a2_s1, b2_s1;
	logic [21:0] a_s1;
	logic [50:0] d2w;
	logic [43:0] a2w, b2w;
	logic [25:0] dm_s1;
	assign dm = d[25] ? 26'(-d) : 26'(d);
	assign ym = ty[23] ? 24'(-ty) : 24'(ty);
	assign d2w = 51'({25'd0, dm} * {25'd0, dm});
	assign y2w = 48'({24'd0, ym} * {24'd0, ym});
	assign a2w = 44'({22'd0, a_len} * {22'd0, a_len});
	assign b2w = 44'({22'd0, b_len} * {22'd0, b_len});
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d2_s1 <= d2w;
			y2_s1 <= y2w;
			a2_s1 <= a2w;
			b2_s1 <= b2w;
			a_s1 <= a_len;
			dm_s1 <= dm;
			dn_s1 <= d[25];
		end
	end

	// stage 2: squared radius and link numerator
	logic        v_s2, dn_s2, pn_s2;
	logic [51:0] rr;
	logic [52:0] p, pm;
	logic [61:0] rr_s2;
	logic [52:0] pm_s2;
	logic [21:0] a_s2;
	logic [25:0] dm_s2;
	assign rr = {1'b0, d2_s1} + {4'd0, y2_s1};
	assign p = {9'd0, a2_s1} + {1'b0, rr};
	assign pm = (p >= {9'd0, b2_s1}) ? p - {9'd0, b2_s1} : {9'd0, b2_s1} - p;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rr_s2 <= {10'd0, rr};
			pm_s2 <= pm;
			pn_s2 <= p < {9'd0, b2_s1};
			a_s2 <= a_s1;
			dm_s2 <= dm_s1;
			dn_s2 <= dn_s1;
		end
	end

	// radius; carry dn, pn, a, dm, pm beside the root stages
	localparam int RS = 1 + 1 + 22 + 26 + 53;
	localparam int NS = fbik_pkg::ISQRT_STEPS;
	logic              rv;
	logic [30:0]       r;
	logic [RS-1:0]     rd [NS+1];
	fbik_isqrt u_r (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2), .in_val(rr_s2),
		.out_valid(rv), .out_root(r)
	);
	assign rd[0] = {dn_s2, pn_s2, a_s2, dm_s2, pm_s2};
	for (genvar k = 0; k < NS; k++) begin : g_rd
		always_ff @(posedge clk) begin
			if (en) begin
				rd[k+1] <= rd[k];
			end
		end
	end
	logic        r_dn, r_pn;
	logic [21:0] r_a;
	logic [25:0] r_dm;
	logic [52:0] r_pm;
	assign {r_dn, r_pn, r_a, r_dm, r_pm} = rd[NS];

	// stage 3: link denominator 2*A*r (22x27 product)
	logic        v_s3, dn_s3, pn_s3;
	logic [26:0] r_s3;
	logic [25:0] dm_s3;
	logic [52:0] pm_s3;
	logic [49:0] ar_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= rv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			ar_s3 <= 50'({28'd0, r_a} * {23'd0, r[26:0]});
			r_s3 <= r[26:0];
			dm_s3 <= r_dm;
			pm_s3 <= r_pm;
			dn_s3 <= r_dn;
			pn_s3 <= r_pn;
		end
	end

	// stage 4: flags; clamp an out-of-reach numerator to the denominator,
	// which stays below 2^47 since A < 2^22 and r < 2^24
	logic [50:0] den;
	logic        z0, l0, far;
	logic [47:0] lmag, lden;
	assign den = {ar_s3, 1'b0};
	assign z0 = r_s3 == '0;
	assign l0 = den == '0;
	assign far = {2'b00, den} < pm_s3;
	assign lmag = far ? den[47:0] : pm_s3[47:0];
	assign lden = den[47:0];

	logic        v_s4, dn_s4, pn_s4, ok_s4;
	logic [47:0] em_s4, ed_s4, lm_s4, ld_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			em_s4 <= z0 ? 48'd1 : {22'd0, dm_s3};
			ed_s4 <= z0 ? 48'd1 : {21'd0, r_s3};
			lm_s4 <= l0 ? 48'd1 : lmag;
			ld_s4 <= l0 ? 48'd1 : lden;
			ok_s4 <= !(z0 || l0 || far);
			dn_s4 <= dn_s3 && !z0;
			pn_s4 <= pn_s3 && !l0;
		end
	end

	logic        qv, qv2;
	logic [30:0] qe, ql;
	logic [1:0]  qs, qs2;
	fbik_div u_de (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.in_mag(em_s4), .in_den(ed_s4), .in_side({ok_s4, dn_s4}),
		.out_valid(qv), .out_q(qe), .out_side(qs)
	);
	fbik_div u_dl (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s4),
		.in_mag(lm_s4), .in_den(ld_s4), .in_side({ok_s4, pn_s4}),
		.out_valid(qv2), .out_q(ql), .out_side(qs2)
	);

	logic signed [31:0] ce, cl;
	assign ce = qs[0] ? -$signed({1'b0, qe}) : $signed({1'b0, qe});
	assign cl = qs2[0] ? -$signed({1'b0, ql}) : $signed({1'b0, ql});

	logic av, av2;
	logic ao, ao2;
	fbik_acos u_ae (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(qv), .in_c(ce),
		.in_side(qs[1]), .out_valid(av), .out_z(eef), .out_side(ao)
	);
	fbik_acos u_al (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(qv2 & qv), .in_c(cl),
		.in_side(qs2[1]), .out_valid(av2), .out_z(link), .out_side(ao2)
	);
	assign out_valid = av & av2;
	assign ok = ao & ao2;
endmodule

// ===== design/five_bar_inverse_kinematics.sv =====
// Top level of the five-bar inverse kinematics pipeline.
// Depends on fbik_pkg and fbik_side.
//
//  channel | dir | payload
//  s_axis  | in  | tdata[23:0] target_x, tdata[47:24] target_y
//  m_axis  | out | tdata[31:0] alpha_angle, tdata[63:32] beta_angle; tuser reachable
//  cfg     | in  | cfg_we, cfg_index (0 half base, 1 upper link, 2 lower link)
//
// One item per cycle while the output is not stalled; an accepted item passes through
// two squaring stages, the 31-stage radius root, two set-up stages, the 30-stage
// ratio dividers, then per arccos one squaring stage, a 31-stage root and
// 28 CORDIC stages, plus the output register.
// Reset clears the configuration and all valid bits.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module five_bar_inverse_kinematics (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // target_x, target_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // alpha_angle, beta_angle
	output logic        m_axis_tuser,   // reachable
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [21:0] cfg_data
);
	logic [21:0] hbw_q, a_q, b_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbw_q <= '0;
			a_q <= '0;
			b_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fbik_pkg::REG_HALF_BASE:  hbw_q <= cfg_data;
				fbik_pkg::REG_UPPER_LINK: a_q <= cfg_data;
				fbik_pkg::REG_LOWER_LINK: b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance the pipeline whenever the output slot is free or empty
	logic en, v1, v2;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic signed [23:0] tx, ty;
	logic signed [25:0] d1, d2;
	assign tx = s_axis_tdata[23:0];
	assign ty = s_axis_tdata[47:24];
	assign d1 = 26'(tx) + $signed({4'd0, hbw_q});
	assign d2 = 26'(tx) - $signed({4'd0, hbw_q});

	logic signed [31:0] e1, k1, e2, k2;
	logic o1, o2;
	fbik_side u_left (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_axis_tvalid),
		.d(d1), .ty(ty), .a_len(a_q), .b_len(b_q),
		.out_valid(v1), .eef(e1), .link(k1), .ok(o1)
	);
	fbik_side u_right (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_axis_tvalid),
		.d(d2), .ty(ty), .a_len(a_q), .b_len(b_q),
		.out_valid(v2), .eef(e2), .link(k2), .ok(o2)
	);

	// output register; hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v1 & v2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {e2 - k2, e1 + k1};
			m_axis_tuser <= o1 & o2;
		end
	end
endmodule

// ===== design/fbik_checker.sv =====
// Port-level checker for the five-bar inverse kinematics top level.
// Depends on nothing but the top level's ports; bound below.
module fbik_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("ready while stalled");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		$stable({m_axis_tuser, m_axis_tdata}) && m_axis_tvalid)
		else $error("output changed under stall");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready) else $error("not ready when empty");
endmodule

bind five_bar_inverse_kinematics fbik_port_props u_fbik_port_props (
	.clk(clk), .arst_n(arst_n), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
